@@ hw/rtl/qfg_pkg.sv @@
// Shared types, constants and codes for the quadratic field gather block.
// No dependencies; imported by qfg_front, qfg_mac, qfg_outq and the top level.
`default_nettype none
package qfg_pkg;

    localparam int DATA_W          = 32;
    localparam int GRID_COUNT      = 10;
    localparam int SEL_W           = 4;
    localparam int IDX_W           = 10;
    localparam int DFN_W           = 20;
    localparam int CFG_IDX_W       = 2;
    localparam int DEF_GRID_NODES  = 1024;
    localparam int FIFO_DEPTH      = 4;
    localparam int W_W             = 17;   // unsigned Q1.16 weight, 1.0 included
    localparam int LOC_W           = 34;   // signed local node index
    localparam int CTR_W           = 33;   // signed centre index
    localparam int DIST_W          = 18;   // signed Q2.16 distance
    localparam int PROD_W          = 50;
    localparam logic [DATA_W-1:0] ICL_RESET = 32'h0001_0000;

    // Grids gathered on the dual centre: Ex, By, Bz and Jx.
    localparam logic [GRID_COUNT-1:0] DUAL_MASK = 10'b00_0111_0001;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_GATHER = 1'b1
    } cmd_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_CELL_LEN = 2'd0,
        CFG_DOMAIN_FIRST = 2'd1
    } cfg_reg_e;

    typedef logic [2:0][W_W-1:0] weight3_t;

    typedef struct packed {
        cmd_e              cmd;
        logic [SEL_W-1:0]  sel;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
    } wr_fields_t;

    typedef struct packed {
        wr_fields_t        wf;
        logic [LOC_W-1:0]  local_p;
        logic [LOC_W-1:0]  local_d;
        weight3_t          wp;
        weight3_t          wd;
    } item_t;

    // One memory step as it travels beside the read data.
    typedef struct packed {
        logic              valid;
        logic              is_write;
        logic              first;
        logic              last;
        logic [W_W-1:0]    wp;
        logic [W_W-1:0]    wd;
        logic              in_p;
        logic              in_d;
    } step_tag_t;

    typedef struct packed {
        logic [GRID_COUNT-1:0][DATA_W-1:0] f;
        logic                              oor;
    } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/qfg_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module qfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire                      rd_en,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/qfg_front.sv @@
// Front pipeline: position scaling, centre rounding, local indexing and spline weights.
// Depends on qfg_pkg.
`default_nettype none
module qfg_front
    import qfg_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire wr_fields_t         in_wf,
    input  wire [DATA_W-1:0]        in_pos,
    input  wire [DATA_W-1:0]        icl,
    input  wire [DFN_W-1:0]         dfn,
    output logic                    out_valid,
    input  wire                     out_ready,
    output item_t                   out_item
);

    function automatic weight3_t spline_weights(input logic signed [DIST_W-1:0] d);
        logic signed [35:0] d2;
        logic signed [35:0] dd;
        logic signed [35:0] t0;
        logic signed [35:0] t2;
        weight3_t           w;
        begin
            d2 = d * d;
            dd = 36'(d) <<< 16;
            t0 = d2 - dd + 36'sd1073741824 + 36'sd65536;
            t2 = d2 + dd + 36'sd1073741824 + 36'sd65536;
            w[0] = t0[33:17];
            w[2] = t2[33:17];
            w[1] = W_W'(17'd65536 - w[0] - w[2]);
            return w;
        end
    endfunction

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic                     rdy2, rdy3, rdy4;
    wr_fields_t               f1_reg, f2_reg, f3_reg;
    logic [DATA_W-1:0]        pos1_reg;
    logic signed [63:0]       x2_reg;
    logic [CTR_W-1:0]         cp3_reg, cd3_reg;
    logic signed [DIST_W-1:0] dp3_reg, dd3_reg;
    item_t                    item4_reg;

    logic signed [64:0]       prod;
    logic [63:0]              s;
    logic                     tie_p, tie_d;
    logic [CTR_W-1:0]         cp_next, cd_next;
    logic [32:0]              bp, bd, rp, rd;
    logic [DIST_W-1:0]        dp_next, dd_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = !v1_reg || rdy2;

    assign prod = $signed(pos1_reg) * $signed({1'b0, icl});

    // Half away from zero: a negative value exactly on a half rounds one further down.
    always_comb begin
        s       = x2_reg + 64'sd2147483648;
        tie_p   = x2_reg[63] && (s[31:0] == 32'd0);
        tie_d   = s[63] && (x2_reg[31:0] == 32'd0);
        cp_next = {s[63], s[63:32]} - CTR_W'(tie_p);
        cd_next = {x2_reg[63], x2_reg[63:32]} + CTR_W'(1) - CTR_W'(tie_d);
        bp      = tie_p ? 33'h1_0000_0000 : {1'b0, s[31:0]};
        bd      = tie_d ? 33'h1_0000_0000 : {1'b0, x2_reg[31:0]};
        rp      = bp + 33'h8000;
        rd      = bd + 33'h8000;
        dp_next = {1'b0, rp[32:16]} - 18'd32768;
        dd_next = {1'b0, rd[32:16]} - 18'd32768;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            f1_reg   <= in_wf;
            pos1_reg <= in_pos;
        end
        if (rdy2) begin
            f2_reg <= f1_reg;
            x2_reg <= prod[63:0];
        end
        if (rdy3) begin
            f3_reg  <= f2_reg;
            cp3_reg <= cp_next;
            cd3_reg <= cd_next;
            dp3_reg <= dp_next;
            dd3_reg <= dd_next;
        end
        if (rdy4) begin
            item4_reg.wf      <= f3_reg;
            item4_reg.local_p <= {cp3_reg[CTR_W-1], cp3_reg} - LOC_W'(dfn);
            item4_reg.local_d <= {cd3_reg[CTR_W-1], cd3_reg} - LOC_W'(dfn);
            item4_reg.wp      <= spline_weights(dp3_reg);
            item4_reg.wd      <= spline_weights(dd3_reg);
        end
    end

    assign out_valid = v4_reg;
    assign out_item  = item4_reg;

endmodule
`default_nettype wire

@@ hw/rtl/qfg_mac.sv @@
// Weighted accumulation of the three stencil nodes of every grid, and rounding.
// Depends on qfg_pkg.
`default_nettype none
module qfg_mac
    import qfg_pkg::*;
(
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire step_tag_t                        tag,
    input  wire [GRID_COUNT-1:0][DATA_W-1:0]      rd_data,
    output logic                                  push,
    output result_t                               push_data
);

    step_tag_t                         tag2_reg;
    logic [GRID_COUNT-1:0][PROD_W-1:0] prod_reg, prod_next;
    logic [GRID_COUNT-1:0][PROD_W-1:0] acc_reg, acc_next;
    logic [GRID_COUNT-1:0][PROD_W-1:0] rsum;
    logic                              oor_reg, oor_next, oor_step;
    logic                              done_reg;
    logic [W_W-1:0]                    w;
    logic                              use_node;

    always_comb begin
        w        = '0;
        use_node = 1'b0;
        for (int g = 0; g < GRID_COUNT; g++) begin
            w        = DUAL_MASK[g] ? tag.wd : tag.wp;
            use_node = !tag.is_write && (DUAL_MASK[g] ? tag.in_d : tag.in_p);
            prod_next[g] = use_node
                ? PROD_W'($signed(rd_data[g]) * $signed({1'b0, w})) : '0;
        end
    end

    always_comb begin
        oor_step = !tag2_reg.is_write && (!tag2_reg.in_p || !tag2_reg.in_d);
        oor_next = tag2_reg.first ? oor_step : (oor_reg || oor_step);
        for (int g = 0; g < GRID_COUNT; g++) begin
            acc_next[g] = tag2_reg.first ? prod_reg[g] : acc_reg[g] + prod_reg[g];
            rsum[g]     = acc_reg[g] + PROD_W'(32768);
            push_data.f[g] = rsum[g][47:16];
        end
        push_data.oor = oor_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag2_reg.valid <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            tag2_reg.valid <= tag.valid;
            done_reg       <= tag2_reg.valid && tag2_reg.last;
        end
        tag2_reg.is_write <= tag.is_write;
        tag2_reg.first    <= tag.first;
        tag2_reg.last     <= tag.last;
        tag2_reg.wp       <= tag.wp;
        tag2_reg.wd       <= tag.wd;
        tag2_reg.in_p     <= tag.in_p;
        tag2_reg.in_d     <= tag.in_d;
        prod_reg          <= prod_next;
        if (tag2_reg.valid) begin
            acc_reg <= acc_next;
            oor_reg <= oor_next;
        end
    end

    assign push = done_reg;

endmodule
`default_nettype wire

@@ hw/rtl/qfg_outq.sv @@
// Small result queue between the accumulator and the result channel.
// Depends on qfg_pkg.
`default_nettype none
module qfg_outq
    import qfg_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  wire result_t     push_data,
    output logic             out_valid,
    input  wire              out_ready,
    output result_t          out_data
);

    localparam int PW = $clog2(FIFO_DEPTH);

    result_t         mem_reg [FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     cnt_reg;
    logic            pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/quadratic_field_gather_1d_top.sv @@
// Top level of the quadratic field gather: configuration, memory sequencer,
// ten grid RAMs. Depends on qfg_pkg, qfg_front, qfg_ram, qfg_mac, qfg_outq.
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      cmd, field_select, node_index, values
//   m_        out        m_valid / m_ready      ten gathered fields, out_of_range
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A gather reads the three stencil nodes in turn, one node of every grid per
// cycle through the single read port of each grid RAM; a write takes one step.
// Reset is synchronous and active low; memory contents are not cleared.
// Four outstanding results, the queue depth, halt the sequencer on a stalled channel.
`default_nettype none
module quadratic_field_gather_1d_top
    import qfg_pkg::*;
#(
    parameter int GRID_NODES = DEF_GRID_NODES
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire                   s_cmd,
    input  wire [SEL_W-1:0]       s_field_select,
    input  wire [IDX_W-1:0]       s_node_index,
    input  wire [DATA_W-1:0]      s_node_value,
    input  wire [DATA_W-1:0]      s_particle_position,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [DATA_W-1:0]     m_e_x,
    output logic [DATA_W-1:0]     m_e_y,
    output logic [DATA_W-1:0]     m_e_z,
    output logic [DATA_W-1:0]     m_b_x,
    output logic [DATA_W-1:0]     m_b_y,
    output logic [DATA_W-1:0]     m_b_z,
    output logic [DATA_W-1:0]     m_j_x,
    output logic [DATA_W-1:0]     m_j_y,
    output logic [DATA_W-1:0]     m_j_z,
    output logic [DATA_W-1:0]     m_rho,
    output logic                  m_out_of_range,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [DATA_W-1:0]      cfg_data
);

    localparam int AW    = $clog2(GRID_NODES);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [DATA_W-1:0]   icl_reg;
    logic [DFN_W-1:0]    dfn_reg;
    wr_fields_t          in_wf;
    logic                front_valid, seq_ready;
    item_t               front_item;

    logic                seq_valid_reg;
    item_t               seq_item_reg;
    logic [1:0]          step_reg;
    logic [CNT_W-1:0]    out_cnt_reg;
    logic                issue, last_step, is_write, pop;
    logic [LOC_W-1:0]    np, nd;
    logic                in_p, in_d;
    step_tag_t           tag_next, tag_reg;

    logic [GRID_COUNT-1:0]             wr_en;
    logic [GRID_COUNT-1:0][DATA_W-1:0] rd_data;
    logic                              push;
    result_t                           push_data, out_data;

    function automatic logic [W_W-1:0] pick_weight(input weight3_t w, input logic [1:0] k);
        logic [W_W-1:0] r;
        begin
            case (k)
                2'd0:    r = w[0];
                2'd1:    r = w[1];
                default: r = w[2];
            endcase
            return r;
        end
    endfunction

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            icl_reg <= ICL_RESET;
            dfn_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_e'(cfg_index))
                CFG_INV_CELL_LEN: icl_reg <= cfg_data;
                CFG_DOMAIN_FIRST: dfn_reg <= cfg_data[DFN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_wf.cmd = cmd_e'(s_cmd);
    assign in_wf.sel = s_field_select;
    assign in_wf.idx = s_node_index;
    assign in_wf.val = s_node_value;

    qfg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_wf     (in_wf),
        .in_pos    (s_particle_position),
        .icl       (icl_reg),
        .dfn       (dfn_reg),
        .out_valid (front_valid),
        .out_ready (seq_ready),
        .out_item  (front_item)
    );

    // Memory sequencer: a new transaction starts only with room for its result.
    always_comb begin
        is_write  = (seq_item_reg.wf.cmd == CMD_WRITE);
        issue     = seq_valid_reg
                    && ((step_reg != 2'd0) || (out_cnt_reg < CNT_W'(FIFO_DEPTH)));
        last_step = is_write || (step_reg == 2'd2);
        seq_ready = !seq_valid_reg || (issue && last_step);
        np        = seq_item_reg.local_p + LOC_W'(step_reg) - LOC_W'(1);
        nd        = seq_item_reg.local_d + LOC_W'(step_reg) - LOC_W'(1);
        in_p      = !np[LOC_W-1] && (np[LOC_W-2:0] < (LOC_W-1)'(GRID_NODES));
        in_d      = !nd[LOC_W-1] && (nd[LOC_W-2:0] < (LOC_W-1)'(GRID_NODES));

        tag_next.valid    = issue;
        tag_next.is_write = is_write;
        tag_next.first    = (step_reg == 2'd0);
        tag_next.last     = last_step;
        tag_next.wp       = pick_weight(seq_item_reg.wp, step_reg);
        tag_next.wd       = pick_weight(seq_item_reg.wd, step_reg);
        tag_next.in_p     = in_p;
        tag_next.in_d     = in_d;

        for (int g = 0; g < GRID_COUNT; g++) begin
            wr_en[g] = issue && is_write && (seq_item_reg.wf.sel == SEL_W'(g))
                       && (17'(seq_item_reg.wf.idx) < 17'(GRID_NODES));
        end
    end

    assign pop = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
            out_cnt_reg   <= '0;
            tag_reg.valid <= 1'b0;
        end else begin
            if (seq_ready) begin
                seq_valid_reg <= front_valid;
                step_reg      <= 2'd0;
            end else if (issue) begin
                step_reg <= step_reg + 2'd1;
            end
            out_cnt_reg   <= out_cnt_reg + CNT_W'(issue && (step_reg == 2'd0))
                             - CNT_W'(pop);
            tag_reg.valid <= tag_next.valid;
        end
        tag_reg.is_write <= tag_next.is_write;
        tag_reg.first    <= tag_next.first;
        tag_reg.last     <= tag_next.last;
        tag_reg.wp       <= tag_next.wp;
        tag_reg.wd       <= tag_next.wd;
        tag_reg.in_p     <= tag_next.in_p;
        tag_reg.in_d     <= tag_next.in_d;
    end

    always_ff @(posedge aclk) begin
        if (seq_ready) begin
            seq_item_reg <= front_item;
        end
    end

    for (genvar g = 0; g < GRID_COUNT; g++) begin : g_grid
        qfg_ram #(
            .WIDTH (DATA_W),
            .DEPTH (GRID_NODES)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (wr_en[g]),
            .wr_addr (AW'(seq_item_reg.wf.idx)),
            .wr_data (seq_item_reg.wf.val),
            .rd_en   (issue && !is_write),
            .rd_addr (DUAL_MASK[g] ? nd[AW-1:0] : np[AW-1:0]),
            .rd_data (rd_data[g])
        );
    end

    qfg_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tag       (tag_reg),
        .rd_data   (rd_data),
        .push      (push),
        .push_data (push_data)
    );

    qfg_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_e_x          = out_data.f[0];
    assign m_e_y          = out_data.f[1];
    assign m_e_z          = out_data.f[2];
    assign m_b_x          = out_data.f[3];
    assign m_b_y          = out_data.f[4];
    assign m_b_z          = out_data.f[5];
    assign m_j_x          = out_data.f[6];
    assign m_j_y          = out_data.f[7];
    assign m_j_z          = out_data.f[8];
    assign m_rho          = out_data.f[9];
    assign m_out_of_range = out_data.oor;

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result credit count exceeds queue depth");

    a_steps_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && (step_reg != 2'd0)) |-> $past(issue))
        else $error("gather steps not issued on consecutive cycles");

    a_write_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && is_write) |-> (step_reg == 2'd0))
        else $error("write transaction issued past its first step");

    a_result_credited: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (out_cnt_reg != '0))
        else $error("result offered without an outstanding transaction");

endmodule
`default_nettype wire
